// ===== design/lsfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfu_pkg
// Shared types, command codes and helpers for the logic/shift flags unit.
// ----------------------------------------------------------------------------
package lsfu_pkg;

  localparam int DataW    = 32;
  localparam int InTdataW  = 80;
  localparam int OutTdataW = 40;

  localparam logic [3:0] CMD_TEST  = 4'd0;
  localparam logic [3:0] CMD_AND   = 4'd1;
  localparam logic [3:0] CMD_OR    = 4'd2;
  localparam logic [3:0] CMD_XOR   = 4'd3;
  localparam logic [3:0] CMD_NOT   = 4'd4;
  localparam logic [3:0] CMD_SAR   = 4'd5;
  localparam logic [3:0] CMD_SHL   = 4'd6;
  localparam logic [3:0] CMD_SHR   = 4'd7;
  localparam logic [3:0] CMD_ROL   = 4'd8;
  localparam logic [3:0] CMD_SETCC = 4'd9;

  localparam logic [1:0] OPW_BYTE  = 2'd0;
  localparam logic [1:0] OPW_WORD  = 2'd1;

  // condition groups, cond_code[3:1]
  localparam logic [2:0] CC_O   = 3'd0;
  localparam logic [2:0] CC_B   = 3'd1;
  localparam logic [2:0] CC_Z   = 3'd2;
  localparam logic [2:0] CC_BE  = 3'd3;
  localparam logic [2:0] CC_S   = 3'd4;
  localparam logic [2:0] CC_P   = 3'd5;
  localparam logic [2:0] CC_L   = 3'd6;

  typedef struct packed {
    logic cf;
    logic of;
    logic zf;
    logic sf;
  } flags_t;

  typedef struct packed {
    logic [3:0]       cond_code;
    logic [1:0]       operand_width;
    logic [DataW-1:0] src_value;
    logic [DataW-1:0] dest_value;
    logic [3:0]       command;
  } item_t;

  function automatic logic [DataW-1:0] width_mask(input logic [1:0] w);
    case (w)
      OPW_BYTE: width_mask = 32'h0000_00ff;
      OPW_WORD: width_mask = 32'h0000_ffff;
      default:  width_mask = 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic msb_of(input logic [DataW-1:0] v, input logic [1:0] w);
    case (w)
      OPW_BYTE: msb_of = v[7];
      OPW_WORD: msb_of = v[15];
      default:  msb_of = v[31];
    endcase
  endfunction

endpackage

// ===== design/x86_logic_shift_flags_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_logic_shift_flags_unit
// x86 logic/shift/rotate/setcc execute unit keeping CF, OF, ZF and SF.
// ----------------------------------------------------------------------------
// channel   dir  width  word
// s_axis    in   80     command, dest_value, src_value, operand_width, cond_code
// m_axis    out  40     result, write_back, carry_flag, overflow_flag,
//                       zero_flag, sign_flag
//
// Input register, then result register.
// One word per cycle sustained while the output is not stalled; flags update
// as a word moves into the result register, so the next word's setcc sees them.
// Reset clears both valid stages and all flags.
// A stalled output blocks the input only when the input register is full.
// ----------------------------------------------------------------------------
module x86_logic_shift_flags_unit
  import lsfu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // command[3:0], dest_value[35:4], src_value[67:36],
  // operand_width[69:68], cond_code[73:70], zero [79:74]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // result[31:0], write_back[32], carry_flag[33], overflow_flag[34],
  // zero_flag[35], sign_flag[36], zero [39:37]
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic             in_valid;
  item_t            in_item;
  logic             out_valid;
  logic [DataW-1:0] out_result;
  logic             out_wb;
  flags_t           flags;
  flags_t           flags_next;
  logic [DataW-1:0] exec_result;
  logic             exec_wb;
  logic             advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  lsfu_exec u_exec (
    .item       (in_item),
    .flags      (flags),
    .result     (exec_result),
    .write_back (exec_wb),
    .flags_next (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        flags     <= flags_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
    if (advance) begin
      out_result <= exec_result;
      out_wb     <= exec_wb;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, flags.sf, flags.zf, flags.of, flags.cf,
                          out_wb, out_result};

endmodule

// ===== design/lsfu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfu_exec
// Combinational execute: logic ops, shifts, rotate, setcc and flag update.
// ----------------------------------------------------------------------------
module lsfu_exec
  import lsfu_pkg::*;
(
  input  item_t            item,
  input  flags_t           flags,
  output logic [DataW-1:0] result,
  output logic             write_back,
  output flags_t           flags_next
);

  logic [DataW-1:0]   mask;
  logic [DataW-1:0]   d;
  logic [DataW-1:0]   s;
  logic [4:0]         cnt;
  logic [DataW-1:0]   sx;
  logic [DataW-1:0]   sar_res;
  logic [2*DataW-1:0] rep;
  logic [2*DataW-1:0] rol_wide;
  logic [DataW-1:0]   rol_res;
  logic [DataW-1:0]   logic_res;
  logic               cond;

  assign mask = width_mask(item.operand_width);
  assign d    = item.dest_value & mask;
  assign s    = item.src_value & mask;
  assign cnt  = item.src_value[4:0];

  always_comb begin
    case (item.operand_width)
      OPW_BYTE: begin
        sx  = {{24{d[7]}}, d[7:0]};
        rep = {8{d[7:0]}};
      end
      OPW_WORD: begin
        sx  = {{16{d[15]}}, d[15:0]};
        rep = {4{d[15:0]}};
      end
      default: begin
        sx  = d;
        rep = {2{d}};
      end
    endcase
  end

  assign sar_res  = DataW'($signed(sx) >>> cnt) & mask;
  // periodic copy makes the upper half a rotate by count mod width
  assign rol_wide = rep << cnt;
  assign rol_res  = rol_wide[2*DataW-1:DataW] & mask;

  always_comb begin
    case (item.command)
      CMD_AND: logic_res = d & s;
      CMD_OR:  logic_res = d | s;
      default: logic_res = d ^ s;
    endcase
  end

  always_comb begin
    case (item.cond_code[3:1])
      CC_O:    cond = flags.of;
      CC_B:    cond = flags.cf;
      CC_Z:    cond = flags.zf;
      CC_BE:   cond = flags.cf | flags.zf;
      CC_S:    cond = flags.sf;
      CC_P:    cond = 1'b0;
      CC_L:    cond = flags.sf ^ flags.of;
      default: cond = flags.zf | (flags.sf ^ flags.of);
    endcase
    if (item.cond_code[3:1] != CC_P) begin
      cond = cond ^ item.cond_code[0];
    end
  end

  always_comb begin
    result     = '0;
    write_back = 1'b0;
    flags_next = flags;
    case (item.command)
      CMD_TEST: begin
        flags_next.cf = 1'b0;
        flags_next.of = 1'b0;
        flags_next.zf = ((d & s) == '0);
        flags_next.sf = msb_of(d & s, item.operand_width);
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        result        = logic_res;
        write_back    = 1'b1;
        flags_next.cf = 1'b0;
        flags_next.of = 1'b0;
        flags_next.zf = (logic_res == '0);
        flags_next.sf = msb_of(logic_res, item.operand_width);
      end
      CMD_NOT: begin
        result     = ~d & mask;
        write_back = 1'b1;
      end
      CMD_SAR, CMD_SHL, CMD_SHR: begin
        if (item.command == CMD_SAR) begin
          result = sar_res;
        end else if (item.command == CMD_SHL) begin
          result = (d << cnt) & mask;
        end else begin
          result = d >> cnt;
        end
        write_back    = 1'b1;
        flags_next.zf = (result == '0);
        flags_next.sf = msb_of(result, item.operand_width);
      end
      CMD_ROL: begin
        result     = rol_res;
        write_back = 1'b1;
        if (cnt != 5'd0) begin
          flags_next.cf = rol_res[0];
          if (cnt == 5'd1) begin
            flags_next.of = msb_of(rol_res, item.operand_width) ^ rol_res[0];
          end
        end
      end
      CMD_SETCC: begin
        result     = {{(DataW-1){1'b0}}, cond};
        write_back = 1'b1;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

// ===== design/lsfu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfu_checker
// Port-level checks for the logic/shift flags unit.
// ----------------------------------------------------------------------------
module lsfu_checker
  import lsfu_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  a_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_no_wb_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == '0)
    else $error("nonzero result without write-back");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OutTdataW-1:37] == '0)
    else $error("output padding not zero");

endmodule

bind x86_logic_shift_flags_unit lsfu_checker u_lsfu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb_x86_logic_shift_flags_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x86_logic_shift_flags_unit
// Self-checking bench for the logic/shift flags unit. A clocked driver feeds
// instruction words from a queue, and a monitor compares every result word
// with an in-order flag-tracking model of the unit. Both stream sides idle at
// random, and the sink holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb_x86_logic_shift_flags_unit;
  import lsfu_pkg::*;

  localparam logic [1:0] OPW_DWORD   = 2'd2;
  localparam logic [1:0] OPW_SPARE   = 2'd3;
  localparam logic [3:0] CMD_LAST    = 4'hf;
  localparam logic [2:0] CC_LE       = 3'd7;
  localparam int         RAND_ITEMS  = 1030;
  localparam int         HOLD_AT     = 300;
  localparam int         HOLD_CYCLES = 90;
  localparam int         DRAIN       = 10;
  localparam int         CYCLE_LIMIT = 300000;

  typedef struct {
    logic [DataW-1:0] result;
    logic             write_back;
    logic             cf;
    logic             of;
    logic             zf;
    logic             sf;
  } alu_out_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // command, dest_value, src_value, operand_width, cond_code, zero pad
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // result, write_back, carry_flag, overflow_flag, zero_flag, sign_flag, pad
  logic [OutTdataW-1:0] m_axis_tdata;

  item_t    pending_insns[$];
  alu_out_t expected_words[$];
  flags_t   arch_flags = '0;
  int       item_total;
  int       items_sent = 0;
  int       words_seen = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       idle_left = 0;
  int       stall_left = 0;
  bit       send_calm = 1'b0;
  bit       sink_calm = 1'b0;
  logic     in_fire = 1'b0;
  logic     out_fire = 1'b0;

  x86_logic_shift_flags_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void zs_update(logic [DataW-1:0] v, int unsigned bits);
    arch_flags.zf = (v == '0);
    arch_flags.sf = v[bits-1];
  endfunction

  function automatic logic cond_true(logic [3:0] cc);
    logic r;
    case (cc[3:1])
      CC_O:    r = arch_flags.of;
      CC_B:    r = arch_flags.cf;
      CC_Z:    r = arch_flags.zf;
      CC_BE:   r = arch_flags.cf | arch_flags.zf;
      CC_S:    r = arch_flags.sf;
      CC_L:    r = arch_flags.sf ^ arch_flags.of;
      CC_LE:   r = arch_flags.zf | (arch_flags.sf ^ arch_flags.of);
      default: r = 1'b0;
    endcase
    // parity is not tracked, so both senses read as false
    return (cc[3:1] == CC_P) ? 1'b0 : r ^ cc[0];
  endfunction

  // in-order model: one instruction in, one result word out, flags carried
  function automatic alu_out_t execute_insn(item_t it);
    int unsigned            bits;
    int unsigned            rot;
    logic [DataW-1:0]       mask;
    logic [DataW-1:0]       d;
    logic [DataW-1:0]       s;
    logic [DataW-1:0]       res;
    logic [DataW-1:0]       sx;
    logic signed [DataW-1:0] sar_tmp;
    logic [2*DataW-1:0]     wide;
    logic [4:0]             cnt;
    alu_out_t               o;
    bits = (it.operand_width == OPW_BYTE) ? 8 : (it.operand_width == OPW_WORD) ? 16 : 32;
    mask = (bits == 32) ? '1 : ((32'd1 << bits) - 32'd1);
    d    = it.dest_value & mask;
    s    = it.src_value & mask;
    cnt  = it.src_value[4:0];
    res  = '0;
    o.write_back = 1'b1;
    case (it.command)
      CMD_TEST: begin
        o.write_back  = 1'b0;
        arch_flags.cf = 1'b0;
        arch_flags.of = 1'b0;
        zs_update(d & s, bits);
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        res = (it.command == CMD_AND) ? (d & s) : (it.command == CMD_OR) ? (d | s) : (d ^ s);
        arch_flags.cf = 1'b0;
        arch_flags.of = 1'b0;
        zs_update(res, bits);
      end
      CMD_NOT: res = ~d & mask;
      CMD_SAR: begin
        sx      = d[bits-1] ? (d | ~mask) : d;
        sar_tmp = $signed(sx) >>> cnt;
        res     = sar_tmp & mask;
        zs_update(res, bits);
      end
      CMD_SHL: begin
        res = (d << cnt) & mask;
        zs_update(res, bits);
      end
      CMD_SHR: begin
        res = (d >> cnt) & mask;
        zs_update(res, bits);
      end
      CMD_ROL: begin
        rot = cnt % bits;
        if (rot == 0) begin
          res = d;
        end else begin
          wide = ({32'b0, d} << rot) | ({32'b0, d} >> (bits - rot));
          res  = wide[DataW-1:0] & mask;
        end
        if (cnt != 0) begin
          arch_flags.cf = res[0];
          if (cnt == 1) arch_flags.of = res[bits-1] ^ arch_flags.cf;
        end
      end
      CMD_SETCC: res = {31'b0, cond_true(it.cond_code)};
      default: o.write_back = 1'b0;
    endcase
    o.result = res;
    o.cf     = arch_flags.cf;
    o.of     = arch_flags.of;
    o.zf     = arch_flags.zf;
    o.sf     = arch_flags.sf;
    return o;
  endfunction

  task automatic check_field(string what, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  function automatic int unsigned pick_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [DataW-1:0] operand_pick();
    logic [DataW-1:0] one_hot;
    one_hot = 32'd1 << $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_insn(logic [3:0] cmd, logic [DataW-1:0] d, logic [DataW-1:0] s,
                            logic [1:0] w, logic [3:0] cc);
    item_t it;
    it.command       = cmd;
    it.dest_value    = d;
    it.src_value     = s;
    it.operand_width = w;
    it.cond_code     = cc;
    pending_insns.push_back(it);
  endtask

  // driver: new word only once the previous one has been taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (in_fire) idle_left = pick_wait(send_calm);
      if (idle_left > 0) begin
        idle_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_insns.size() > 0) begin
        s_axis_tdata  <= {{(InTdataW - $bits(item_t)){1'b0}}, pending_insns.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink: random stalls, one long hold-off to fill the pipe
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_fire) stall_left = (words_seen == HOLD_AT) ? HOLD_CYCLES : pick_wait(sink_calm);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    alu_out_t want;
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("result", want.result, m_axis_tdata[31:0]);
          check_field("write_back", DataW'(want.write_back), DataW'(m_axis_tdata[32]));
          check_field("carry_flag", DataW'(want.cf), DataW'(m_axis_tdata[33]));
          check_field("overflow_flag", DataW'(want.of), DataW'(m_axis_tdata[34]));
          check_field("zero_flag", DataW'(want.zf), DataW'(m_axis_tdata[35]));
          check_field("sign_flag", DataW'(want.sf), DataW'(m_axis_tdata[36]));
        end
        words_seen <= words_seen + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(execute_insn(item_t'(s_axis_tdata[$bits(item_t)-1:0])));
        items_sent <= items_sent + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    item_t      it;
    int         pick;
    logic [4:0] cnt;
    // directed: edges of each op
    queue_insn(CMD_SETCC, '0, '0, OPW_BYTE, 4'h4);
    queue_insn(CMD_AND, 32'hffff_ffff, 32'h0000_00ff, OPW_BYTE, '0);
    queue_insn(CMD_XOR, 32'hffff_ffff, 32'hffff_ffff, OPW_DWORD, '0);
    queue_insn(CMD_SETCC, '0, '0, OPW_BYTE, 4'h4);
    queue_insn(CMD_OR, 32'h0001_8000, '0, OPW_WORD, '0);
    queue_insn(CMD_TEST, 32'h8000_0000, 32'hffff_ffff, OPW_DWORD, '0);
    queue_insn(CMD_NOT, 32'hffff_ff00, '0, OPW_BYTE, '0);
    queue_insn(CMD_NOT, 32'hffff_ffff, '0, OPW_DWORD, '0);
    queue_insn(CMD_SAR, 32'h0000_0080, 32'd7, OPW_BYTE, '0);
    queue_insn(CMD_SAR, 32'h0000_0080, 32'd31, OPW_BYTE, '0);
    queue_insn(CMD_SAR, 32'h0000_4000, 32'd20, OPW_WORD, '0);
    queue_insn(CMD_SHL, 32'h0000_0001, 32'd31, OPW_DWORD, '0);
    queue_insn(CMD_SHL, 32'h0000_0001, 32'd8, OPW_BYTE, '0);
    queue_insn(CMD_SHR, 32'hffff_ffff, 32'd32, OPW_DWORD, '0);
    queue_insn(CMD_SHR, 32'h0000_ffff, 32'hffff_fff0, OPW_WORD, '0);
    queue_insn(CMD_ROL, 32'h0000_0081, 32'd1, OPW_BYTE, '0);
    queue_insn(CMD_SETCC, '0, '0, OPW_BYTE, 4'h0);
    queue_insn(CMD_ROL, 32'h8000_0000, 32'd0, OPW_DWORD, '0);
    queue_insn(CMD_ROL, 32'h0000_1235, 32'd16, OPW_WORD, '0);
    queue_insn(CMD_ROL, 32'h8000_0001, 32'd32, OPW_DWORD, '0);
    queue_insn(CMD_SETCC, '0, '0, OPW_BYTE, 4'ha);
    queue_insn(CMD_SETCC, '0, '0, OPW_BYTE, 4'hb);
    queue_insn(CMD_SETCC, '0, '0, OPW_BYTE, 4'hf);
    queue_insn(CMD_AND, 32'h8000_0000, 32'hffff_ffff, OPW_SPARE, 4'hf);
    queue_insn(4'(CMD_SETCC + 1), 32'hffff_ffff, 32'hffff_ffff, OPW_SPARE, 4'hf);
    queue_insn(CMD_LAST, 32'hffff_ffff, 32'hffff_ffff, OPW_BYTE, 4'h7);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) it.command = 4'($urandom_range(CMD_SETCC + 1, CMD_LAST));
      else if (pick < 24) it.command = CMD_SETCC;
      else it.command = 4'($urandom_range(CMD_TEST, CMD_ROL));
      it.dest_value    = operand_pick();
      it.operand_width = 2'($urandom_range(0, 3));
      it.cond_code     = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0:       it.src_value = it.dest_value;
        1:       it.src_value = ~it.dest_value;
        default: it.src_value = operand_pick();
      endcase
      if (it.command inside {CMD_SAR, CMD_SHL, CMD_SHR, CMD_ROL}) begin
        case ($urandom_range(0, 3))
          0:       cnt = 5'($urandom_range(0, 2));
          1:       cnt = 5'((5'd8 << $urandom_range(0, 2)) - $urandom_range(0, 1));
          default: cnt = 5'($urandom);
        endcase
        it.src_value[4:0] = cnt;
      end
      pending_insns.push_back(it);
    end
    item_total = pending_insns.size();

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (items_sent != item_total) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
